/* src/mvp_pkg.sv */
// Shared types and constants for the matrix-vector product engine.
// No dependencies; imported by every module of the block except mvp_ram.
package mvp_pkg;

   localparam int DATA_W              = 32;
   localparam int INDEX_W             = 10;
   localparam int COLUMN_COUNT_W      = 11;
   localparam int ROW_COUNT_W         = 16;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 16;
   localparam int MAX_COLUMNS_DEFAULT = 1024;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_MATRIX = 1'b1
   } opcode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'b1;

   typedef struct packed {
      logic valid;
      logic end_row;
      logic last_row;
   } tag_type;

endpackage

/* src/mvp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mvp_ctrl.sv */
// Input side: config registers, column/row counters, vector store access.
// Depends on mvp_pkg.
module mvp_ctrl #(
   parameter int MAX_COLUMNS = mvp_pkg::MAX_COLUMNS_DEFAULT,
   localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mvp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mvp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   input  logic                              req_opcode,
   input  logic [mvp_pkg::INDEX_W-1:0]       req_vector_index,
   input  logic [mvp_pkg::DATA_W-1:0]        req_value,
   input  logic                              advance,
   output logic                              ram_wr_en,
   output logic [ADDR_W-1:0]                 ram_wr_addr,
   output logic [mvp_pkg::DATA_W-1:0]        ram_wr_data,
   output logic                              ram_rd_en,
   output logic [ADDR_W-1:0]                 ram_rd_addr,
   output mvp_pkg::tag_type                  s1_tag,
   output logic [mvp_pkg::DATA_W-1:0]        s1_value
);

   import mvp_pkg::*;

   localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int EFF_W = (CNT_W > COLUMN_COUNT_W) ? CNT_W : COLUMN_COUNT_W;
   localparam logic [EFF_W-1:0] MAX_EFF = EFF_W'(MAX_COLUMNS);
   localparam logic [16:0]      MAX_IDX = 17'(MAX_COLUMNS);

   logic [COLUMN_COUNT_W-1:0] column_count_ff;
   logic [ROW_COUNT_W-1:0]    row_count_ff;
   logic [ADDR_W-1:0]         column_ff, column_in;
   logic [ROW_COUNT_W-1:0]    row_ff, row_in;
   tag_type                   tag_ff, tag_in;
   logic [DATA_W-1:0]         value_ff;

   logic                      accept;
   logic                      is_matrix;
   logic [EFF_W-1:0]          count_ext;
   logic [EFF_W-1:0]          eff_columns;
   logic [EFF_W-1:0]          column_next;
   logic [ROW_COUNT_W-1:0]    eff_rows;
   logic [ROW_COUNT_W:0]      row_next;
   logic                      end_row;
   logic                      last_row;
   logic [16:0]               index_ext;
   logic [ADDR_W+INDEX_W-1:0] index_wide;

   assign accept    = req_valid && advance;
   assign is_matrix = (req_opcode == OP_MATRIX);

   assign count_ext   = EFF_W'(column_count_ff);
   assign eff_columns = (column_count_ff == '0) ? EFF_W'(1) :
                        (count_ext > MAX_EFF) ? MAX_EFF : count_ext;
   assign column_next = EFF_W'(column_ff) + EFF_W'(1);
   assign end_row     = (column_next >= eff_columns);

   assign eff_rows = (row_count_ff == '0) ? ROW_COUNT_W'(1) : row_count_ff;
   assign row_next = {1'b0, row_ff} + 17'd1;
   assign last_row = (row_next >= {1'b0, eff_rows});

   assign index_ext  = {7'd0, req_vector_index};
   assign index_wide = {{ADDR_W{1'b0}}, req_vector_index};

   assign ram_wr_en   = accept && !is_matrix && (index_ext < MAX_IDX);
   assign ram_wr_addr = index_wide[ADDR_W-1:0];
   assign ram_wr_data = req_value;
   assign ram_rd_en   = accept && is_matrix;
   assign ram_rd_addr = column_ff;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept && is_matrix) begin
         if (end_row) begin
            column_in = '0;
            row_in    = last_row ? '0 : row_next[ROW_COUNT_W-1:0];
         end else begin
            column_in = column_ff + ADDR_W'(1);
         end
      end
      tag_in.valid    = accept && is_matrix;
      tag_in.end_row  = end_row;
      tag_in.last_row = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_W'(1);
         row_count_ff    <= ROW_COUNT_W'(1);
         column_ff       <= '0;
         row_ff          <= '0;
         tag_ff          <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_COLUMN_COUNT: column_count_ff <= csr_write_data[COLUMN_COUNT_W-1:0];
               CSR_ROW_COUNT:    row_count_ff    <= csr_write_data[ROW_COUNT_W-1:0];
               default:          ;
            endcase
         end
         column_ff <= column_in;
         row_ff    <= row_in;
         if (advance) begin
            tag_ff <= tag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= req_value;
      end
   end

   assign s1_tag   = tag_ff;
   assign s1_value = value_ff;

endmodule

/* src/mvp_mac.sv */
// Multiply stage, row accumulator and result output register.
// Depends on mvp_pkg.
module mvp_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  mvp_pkg::tag_type           s1_tag,
   input  logic [mvp_pkg::DATA_W-1:0] s1_value,
   input  logic [mvp_pkg::DATA_W-1:0] s1_vector,
   input  logic                       rsp_stall,
   output logic                       advance,
   output logic                       rsp_valid,
   output logic [mvp_pkg::DATA_W-1:0] rsp_row_sum,
   output logic                       rsp_last_row
);

   import mvp_pkg::*;

   tag_type           tag_ff;
   logic [DATA_W-1:0] product_ff, product_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] row_sum_ff;
   logic              last_row_ff;
   logic [DATA_W-1:0] total;
   logic              emit;

   assign product_in = s1_value * s1_vector;
   assign total      = sum_ff + product_ff;
   assign emit       = tag_ff.valid && tag_ff.end_row;
   assign advance    = !(emit && valid_ff && rsp_stall);

   always_comb begin
      sum_in   = sum_ff;
      valid_in = valid_ff && rsp_stall;
      if (advance && tag_ff.valid) begin
         sum_in = tag_ff.end_row ? '0 : total;
         if (tag_ff.end_row) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            tag_ff <= s1_tag;
         end
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= product_in;
      end
      if (advance && emit) begin
         row_sum_ff  <= total;
         last_row_ff <= tag_ff.last_row;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_row_sum  = row_sum_ff;
   assign rsp_last_row = last_row_ff;

endmodule

/* src/matrix_vector_product.sv */
// Top level of the matrix-vector product engine.
// Depends on mvp_pkg, mvp_ram, mvp_ctrl and mvp_mac.
//
//   channel  direction  handshake          word
//   req_     in         valid / stall      opcode, vector_index, value
//   rsp_     out        valid / stall      row_sum, last_row
//   csr_     in         write_enable       index, write_data
//
// One word per cycle is accepted while req_stall is low, loads and matrix elements alike.
// A matrix element passes store read, multiply and accumulate; the row sum is
// registered onto rsp_ after the row's last element has passed the store read and multiply registers.
// Reset clears counters and accumulator and sets both config registers to 1;
// the vector store is not cleared and needs no clearing pass.
// req_stall rises only while a finished row sum waits under rsp_stall and the next one is ready.
module matrix_vector_product #(
   parameter int MAX_COLUMNS = mvp_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [mvp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mvp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [mvp_pkg::INDEX_W-1:0]      req_vector_index,
   input  logic signed [mvp_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [mvp_pkg::DATA_W-1:0] rsp_row_sum,
   output logic                             rsp_last_row
);

   import mvp_pkg::*;

   localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic              advance;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   tag_type           s1_tag;
   logic [DATA_W-1:0] s1_value;
   logic [DATA_W-1:0] row_sum;

   assign req_stall = !advance;

   mvp_ctrl #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_opcode       (req_opcode),
      .req_vector_index (req_vector_index),
      .req_value        (req_value),
      .advance          (advance),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .s1_tag           (s1_tag),
      .s1_value         (s1_value)
   );

   mvp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_COLUMNS)
   ) u_vector_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mvp_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .s1_tag       (s1_tag),
      .s1_value     (s1_value),
      .s1_vector    (ram_rd_data),
      .rsp_stall    (rsp_stall),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_row_sum  (row_sum),
      .rsp_last_row (rsp_last_row)
   );

   assign rsp_row_sum = row_sum;

endmodule

/* bench/testbench.sv */
// Self-checking bench for matrix_vector_product: streams vector loads and matrix
// elements, predicts each row sum in-bench and compares every result word.
// Depends on mvp_pkg and the matrix_vector_product RTL.
module testbench;
   import mvp_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      opcode_type             opcode;
      logic [INDEX_W-1:0]     vector_index;
      logic [DATA_W-1:0]      value;
   } req_word_type;

   typedef struct {
      logic signed [DATA_W-1:0] row_sum;
      logic                     last_row;
   } row_sum_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index        = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_opcode       = 1'b0;
   logic [INDEX_W-1:0]        req_vector_index = '0;
   logic signed [DATA_W-1:0]  req_value        = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0]  rsp_row_sum;
   logic                      rsp_last_row;

   req_word_type word_queue[$];
   row_sum_type  pending_sums[$];
   req_word_type offered;
   row_sum_type  want;

   logic [DATA_W-1:0]         vec_image [MAX_COLUMNS_DEFAULT];
   int unsigned               col_pos     = 0;
   int unsigned               row_pos     = 0;
   logic [DATA_W-1:0]         row_acc     = '0;
   logic [COLUMN_COUNT_W-1:0] cfg_columns = 1;
   logic [ROW_COUNT_W-1:0]    cfg_rows    = 1;

   bit          loaded [MAX_COLUMNS_DEFAULT];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_trigger  = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          quiet_cycles  = 0;
   int          errors        = 0;
   int          words_sent    = 0;
   int          sums_checked  = 0;
   int          csr_writes    = 0;

   matrix_vector_product dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_vector_index (req_vector_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_sum      (rsp_row_sum),
      .rsp_last_row     (rsp_last_row)
   );

   always #10 clock = ~clock;

   task automatic accumulate_word(input req_word_type w);
      int unsigned       eff_cols;
      int unsigned       eff_rows;
      logic [DATA_W-1:0] product;
      logic              final_row;
      row_sum_type       result;
      if (w.opcode == OP_LOAD) begin
         vec_image[w.vector_index] = w.value;
      end else begin
         eff_cols = (cfg_columns == 0) ? 1 :
                    (cfg_columns > MAX_COLUMNS_DEFAULT) ? MAX_COLUMNS_DEFAULT : cfg_columns;
         eff_rows = (cfg_rows == 0) ? 1 : cfg_rows;
         product  = w.value * vec_image[INDEX_W'(col_pos)];
         row_acc  = row_acc + product;
         if (col_pos + 1 < eff_cols) begin
            col_pos++;
         end else begin
            final_row       = (row_pos + 1 >= eff_rows);
            result.row_sum  = row_acc;
            result.last_row = final_row;
            pending_sums.push_back(result);
            row_acc = '0;
            col_pos = 0;
            row_pos = final_row ? 0 : row_pos + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_word(offered);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = word_queue.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= offered.opcode;
               req_vector_index <= offered.vector_index;
               req_value        <= offered.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               errors++;
               $display("%0t: unexpected row sum: expected none, actual %0d last_row %0b",
                        $time, rsp_row_sum, rsp_last_row);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_row_sum !== want.row_sum) begin
                  errors++;
                  $display("%0t: row_sum mismatch: expected %0d, actual %0d",
                           $time, want.row_sum, rsp_row_sum);
               end
               if (rsp_last_row !== want.last_row) begin
                  errors++;
                  $display("%0t: last_row mismatch: expected %0b, actual %0b",
                           $time, want.last_row, rsp_last_row);
               end
               sums_checked++;
            end
         end
         if (hold_trigger != hold_served) begin
            hold_served = hold_trigger;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(3))
         0: random_value = $urandom_range(16) - 8;
         1: begin
            case ($urandom_range(3))
               0: random_value = 32'h8000_0000;
               1: random_value = 32'h7fff_ffff;
               2: random_value = 32'hffff_ffff;
               default: random_value = '0;
            endcase
         end
         default: random_value = $urandom;
      endcase
   endfunction

   task automatic push_load(input int unsigned idx, input logic [DATA_W-1:0] val);
      req_word_type w;
      w.opcode       = OP_LOAD;
      w.vector_index = INDEX_W'(idx);
      w.value        = val;
      loaded[w.vector_index] = 1'b1;
      word_queue.push_back(w);
   endtask

   task automatic push_matrix(input logic [DATA_W-1:0] val);
      req_word_type w;
      w.opcode       = OP_MATRIX;
      w.vector_index = INDEX_W'($urandom_range(MAX_COLUMNS_DEFAULT - 1));
      w.value        = val;
      word_queue.push_back(w);
   endtask

   task automatic drain_and_settle();
      while (word_queue.size() != 0 || req_valid || pending_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      if (index == CSR_COLUMN_COUNT)
         cfg_columns = data[COLUMN_COUNT_W-1:0];
      else
         cfg_rows = data[ROW_COUNT_W-1:0];
      csr_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic matrix_phase(input int unsigned columns, input int unsigned rows,
                               input int unsigned elements);
      int unsigned eff_cols;
      drain_and_settle();
      write_register(CSR_COLUMN_COUNT,
                     CSR_DATA_W'(($urandom_range(31) << COLUMN_COUNT_W) | columns));
      write_register(CSR_ROW_COUNT, CSR_DATA_W'(rows));
      eff_cols = (columns == 0) ? 1 :
                 (columns > MAX_COLUMNS_DEFAULT) ? MAX_COLUMNS_DEFAULT : columns;
      for (int i = 0; i < eff_cols; i++)
         if (!loaded[INDEX_W'(i)]) push_load(i, random_value());
      for (int e = 0; e < elements; e++) begin
         if ($urandom_range(7) == 0) push_load($urandom_range(MAX_COLUMNS_DEFAULT - 1),
                                               random_value());
         push_matrix(random_value());
      end
   endtask

   task automatic random_phase(input int unsigned max_cols, input int unsigned max_rows);
      int unsigned columns;
      int unsigned rows;
      int unsigned eff_c;
      int unsigned eff_r;
      int unsigned elements;
      columns  = $urandom_range(max_cols);
      rows     = $urandom_range(max_rows);
      eff_c    = (columns == 0) ? 1 : columns;
      eff_r    = (rows == 0) ? 1 : rows;
      elements = eff_c * eff_r * $urandom_range(1, 3);
      // sometimes add one to eff_c more elements, which may leave a partial row for the next setting to pick up
      if ($urandom_range(3) == 0) elements += $urandom_range(1, eff_c);
      matrix_phase(columns, rows, elements);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 46;

      push_load(0, 32'h7fff_ffff);
      push_load(MAX_COLUMNS_DEFAULT - 1, 32'hffff_ffff);
      push_matrix(32'h8000_0000);
      push_matrix(32'hffff_ffff);
      push_matrix(32'h0000_0000);
      push_matrix(32'h7fff_ffff);
      push_load(0, 32'hffff_ffff);
      push_matrix(32'h8000_0000);
      drain_and_settle();
      write_register(CSR_COLUMN_COUNT, '0);
      write_register(CSR_ROW_COUNT, '0);
      push_matrix(32'd5);
      push_matrix(-32'sd3);
      drain_and_settle();
      write_register(CSR_COLUMN_COUNT, 2);
      write_register(CSR_ROW_COUNT, 3);
      push_load(1, 32'h8000_0000);
      push_matrix(32'h7fff_ffff);
      push_matrix(32'h8000_0000);
      push_matrix(32'hffff_ffff);
      push_matrix(32'h0000_0001);
      push_matrix(32'h0000_0000);
      push_matrix(32'h8000_0000);

      repeat (6) random_phase(12, 6);

      send_idle_pct = 46;
      recv_idle_pct = 38;
      matrix_phase(1, $urandom_range(1, 4), 60);
      hold_trigger++;
      matrix_phase(5, 3, 23);
      matrix_phase(5, 3, 22);
      matrix_phase(2, 65535, 20);
      matrix_phase(2, 2, 6);
      matrix_phase(2047, 1, 40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (6) random_phase(12, 6);
      matrix_phase(1, 1, 40);

      drain_and_settle();
      $display("Covered %0d words and %0d register writes; %0d row sums checked.",
               words_sent, csr_writes, sums_checked);
      $display("Column counts 0 to 2047, row counts 0 to 65535, mid-row changes, long hold-off.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
src/mvp_pkg.sv
src/mvp_ram.sv
src/mvp_ctrl.sv
src/mvp_mac.sv
src/matrix_vector_product.sv
bench/testbench.sv
